// ===== sv/agdc_pkg.sv =====
`timescale 1ns / 1ps
package agdc_pkg;

	// operand and product widths of the shared multiplier
	localparam int OPW  = 64;
	localparam int LIMB = 32;
	localparam int PW   = 128;
	localparam int MUL_STEPS = 4;

	// reciprocal divider: 2^32 / limit_factor, 33 quotient bits
	localparam int QW        = 33;
	localparam int DIV_STEPS = 33;
	localparam int DVW       = 32;

	// register file
	localparam int REG_W  = 32;
	localparam int HYST_W = 12;
	localparam int IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_TARGET = 3'd0;
	localparam logic [IDX_W-1:0] REG_HYST   = 3'd1;
	localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd2;
	localparam logic [IDX_W-1:0] REG_IGAIN  = 3'd3;
	localparam logic [IDX_W-1:0] REG_DGAIN  = 3'd4;
	localparam logic [IDX_W-1:0] REG_DLIMIT = 3'd5;

	// Q16.16 arithmetic
	localparam int FRAC   = 16;
	localparam int TERM_W = 48;   // (32b * 32b) >> 16
	localparam int CORR_W = 51;   // signed correction factor

	localparam logic [REG_W-1:0]  LIMIT_RST  = 32'h0001_0000;
	localparam logic [REG_W-1:0]  DLIMIT_RST = 32'hFFFF_FFFF;
	localparam logic signed [CORR_W-1:0] CORR_ONE   = 51'sd65536;
	localparam logic signed [CORR_W-1:0] CORR_RECIP_MAX = 51'sd4294967296;

	typedef struct packed {
		logic           start;
		logic [OPW-1:0] a;
		logic [OPW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic          done;
		logic [PW-1:0] p;
	} mul_rsp_t;

	typedef struct packed {
		logic           start;
		logic [DVW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [QW-1:0] quo;
	} div_rsp_t;

endpackage

// ===== sv/agdc_mul.sv =====
`timescale 1ns / 1ps
module agdc_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  agdc_pkg::mul_req_t req,
	output agdc_pkg::mul_rsp_t rsp
);
	import agdc_pkg::*;

	// 64x64 product from four 32x32 limb products, one per cycle
	logic [OPW-1:0]   a_q;
	logic [OPW-1:0]   b_q;
	logic [PW-1:0]    acc_q;
	logic [2:0]       step_q;
	logic             busy_q;
	logic [2*LIMB-1:0] prod_s1;
	logic [1:0]       off_s1;
	logic             prod_vld_s1;

	logic [LIMB-1:0] a_limb;
	logic [LIMB-1:0] b_limb;
	logic [1:0]      off;
	logic [PW-1:0]   addend;
	logic            done;

	assign a_limb = step_q[1] ? a_q[OPW-1:LIMB] : a_q[LIMB-1:0];
	assign b_limb = step_q[0] ? b_q[OPW-1:LIMB] : b_q[LIMB-1:0];
	assign off    = {1'b0, step_q[1]} + {1'b0, step_q[0]};

	always_comb begin
		case (off_s1)
			2'd0:    addend = {64'b0, prod_s1};
			2'd1:    addend = {32'b0, prod_s1, 32'b0};
			2'd2:    addend = {prod_s1, 64'b0};
			default: addend = '0;
		endcase
	end

	assign done = busy_q && (step_q == 3'(MUL_STEPS)) && !prod_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			prod_vld_s1 <= 1'b0;
			a_q         <= '0;
			b_q         <= '0;
			acc_q       <= '0;
			prod_s1     <= '0;
			off_s1      <= '0;
		end else if (req.start) begin
			busy_q      <= 1'b1;
			step_q      <= '0;
			prod_vld_s1 <= 1'b0;
			a_q         <= req.a;
			b_q         <= req.b;
			acc_q       <= '0;
		end else if (busy_q) begin
			if (step_q != 3'(MUL_STEPS)) begin
				prod_s1     <= a_limb * b_limb;
				off_s1      <= off;
				prod_vld_s1 <= 1'b1;
				step_q      <= step_q + 3'd1;
			end else begin
				prod_vld_s1 <= 1'b0;
			end
			if (prod_vld_s1) begin
				acc_q <= acc_q + addend;
			end
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign rsp.done = done;
	assign rsp.p    = acc_q;

endmodule

// ===== sv/agdc_div.sv =====
`timescale 1ns / 1ps
module agdc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  agdc_pkg::div_req_t req,
	output agdc_pkg::div_rsp_t rsp
);
	import agdc_pkg::*;

	// restoring divider for 2^32 / d, one quotient bit per cycle
	logic [DVW-1:0] d_q;
	logic [DVW-1:0] rem_q;
	logic [QW-1:0]  num_q;
	logic [QW-1:0]  quo_q;
	logic [5:0]     cnt_q;
	logic           busy_q;

	logic [DVW:0] trial;
	logic [DVW:0] diff;
	logic         fits;

	assign trial = {rem_q, num_q[QW-1]};
	assign diff  = trial - {1'b0, d_q};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			d_q    <= '0;
			rem_q  <= '0;
			num_q  <= '0;
			quo_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'(DIV_STEPS);
			d_q    <= req.divisor;
			rem_q  <= '0;
			num_q  <= {1'b1, {(QW-1){1'b0}}};
			quo_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				rem_q <= fits ? diff[DVW-1:0] : trial[DVW-1:0];
				quo_q <= {quo_q[QW-2:0], fits};
				num_q <= {num_q[QW-2:0], 1'b0};
				cnt_q <= cnt_q - 6'd1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	assign rsp.done = busy_q && (cnt_q == '0);
	assign rsp.quo  = quo_q;

endmodule

// ===== sv/adaptive_gain_dose_controller.sv =====
`timescale 1ns / 1ps
// channel | dir | signals                          | contents
// s       | in  | s_tvalid s_tready s_tdata        | pressure_sample (Q4.12)
// m       | out | m_tvalid m_tready m_tdata m_tuser| dose_amount (Q16.16), dose_given
// cfg     | in  | cfg_we cfg_index cfg_data        | register write, no wait state
//
// One request at a time; s_tready is high only while the sequencer is idle.
// Without a pending adaptation a dosed request makes one limb multiplier pass,
// an undosed one none. A pending adaptation adds three multiplier passes, two
// if the correction clears the gain, plus a reciprocal divider pass when the
// error lies below the band with a nonzero limit. A stalled output result
// holds the sequencer. Reset is asynchronous, active low, and restores all state.
module adaptive_gain_dose_controller #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int GAIN_WIDTH   = 32,
	localparam int SDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [SDATA_W-1:0]         s_tdata,   // [SAMPLE_WIDTH-1:0] pressure_sample
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [31:0]                m_tdata,   // [31:0] dose_amount
	output logic                       m_tuser,   // [0] dose_given
	input  logic                       cfg_we,
	input  logic [agdc_pkg::IDX_W-1:0] cfg_index,
	input  logic [agdc_pkg::REG_W-1:0] cfg_data
);
	import agdc_pkg::*;

	// compare width: holds any error, difference or band value signed
	localparam int CW = ((SAMPLE_WIDTH > HYST_W) ? SAMPLE_WIDTH : HYST_W) + 3;
	localparam int IW = SAMPLE_WIDTH + 2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_TI_G, ST_TI_W, ST_TD_G, ST_TD_W, ST_BASE, ST_DV_G, ST_DV_W,
		ST_CI, ST_CD, ST_GN_G, ST_GN_W, ST_DOSE, ST_DS_G, ST_DS_W, ST_OUT
	} state_t;

	// configuration registers
	logic [SAMPLE_WIDTH-1:0] target_q;
	logic [HYST_W-1:0]       hyst_q;
	logic [REG_W-1:0]        limit_q;
	logic [REG_W-1:0]        igain_q;
	logic [REG_W-1:0]        dgain_q;
	logic [REG_W-1:0]        dlimit_q;

	// controller state
	state_t                  state_q;
	logic [GAIN_WIDTH-1:0]   gain_q;
	logic [SAMPLE_WIDTH-1:0] psample_q;
	logic [SAMPLE_WIDTH-1:0] ptarget_q;
	logic signed [IW-1:0]    integ_q;
	logic                    pend_q;

	// per-request working registers
	logic [SAMPLE_WIDTH-1:0]  sample_q;
	logic [TERM_W-1:0]        ti_q;
	logic [TERM_W-1:0]        td_q;
	logic signed [CORR_W-1:0] corr_q;
	logic [31:0]              dose_q;
	logic                     given_q;

	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic        m_tuser_q;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;

	agdc_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));
	agdc_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// error terms, all exact signed values
	logic signed [CW-1:0] err_x;
	logic signed [CW-1:0] last_x;
	logic signed [CW-1:0] diff_x;
	logic signed [CW-1:0] hyst_x;
	logic signed [CW-1:0] nhyst_x;
	logic signed [CW-1:0] integ_x;
	logic signed [IW-1:0] sum_i;
	logic [CW-1:0]        mag_full;
	logic [SAMPLE_WIDTH-1:0] mag;
	logic                 dosed;
	logic signed [CORR_W-1:0] ti_s;
	logic signed [CORR_W-1:0] td_s;
	logic [GAIN_WIDTH-1:0] gain_new;
	logic [31:0]           dose_raw;
	logic [31:0]           dose_cap;
	logic                  out_load;

	assign err_x    = CW'(target_q) - CW'(sample_q);
	assign last_x   = CW'(ptarget_q) - CW'(psample_q);
	assign diff_x   = err_x - last_x;
	assign hyst_x   = signed'(CW'(hyst_q));
	assign nhyst_x  = -hyst_x;
	assign integ_x  = CW'(integ_q);
	assign sum_i    = integ_q + signed'(err_x[IW-1:0]);
	assign mag_full = err_x[CW-1] ? -err_x : err_x;
	assign mag      = mag_full[SAMPLE_WIDTH-1:0];
	// sample < target + band
	assign dosed    = err_x > nhyst_x;
	assign ti_s     = signed'(CORR_W'(ti_q));
	assign td_s     = signed'(CORR_W'(td_q));

	// gain: (gain * corr) >> 16, saturating
	assign gain_new = (|mul_rsp.p[PW-1:GAIN_WIDTH+FRAC]) ? '1
	                                                     : mul_rsp.p[GAIN_WIDTH+FRAC-1:FRAC];
	// dose: (|err| * gain) >> fraction bits of the sample, capped at dose_limit
	assign dose_raw = (|mul_rsp.p[PW-1:SAMPLE_WIDTH+28]) ? '1
	                                                     : mul_rsp.p[SAMPLE_WIDTH+27:SAMPLE_WIDTH-4];
	assign dose_cap = (dose_raw > dlimit_q) ? dlimit_q : dose_raw;

	// multiplier operands only matter in the start cycle
	always_comb begin
		mul_req.start = 1'b0;
		mul_req.a     = '0;
		mul_req.b     = '0;
		case (state_q)
			ST_TI_G: begin
				mul_req.start = 1'b1;
				mul_req.a     = OPW'(limit_q);
				mul_req.b     = OPW'(igain_q);
			end
			ST_TD_G: begin
				mul_req.start = 1'b1;
				mul_req.a     = OPW'(limit_q);
				mul_req.b     = OPW'(dgain_q);
			end
			ST_GN_G: begin
				// no product when the gain is cleared
				mul_req.start = (corr_q > 0);
				mul_req.a     = OPW'(gain_q);
				mul_req.b     = OPW'(corr_q[CORR_W-2:0]);
			end
			ST_DS_G: begin
				mul_req.start = 1'b1;
				mul_req.a     = OPW'(mag);
				mul_req.b     = OPW'(gain_q);
			end
			default: begin
			end
		endcase
	end

	assign div_req.start   = (state_q == ST_DV_G);
	assign div_req.divisor = limit_q;

	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// register file; the setpoint copy into prior target lives with the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			hyst_q   <= '0;
			limit_q  <= LIMIT_RST;
			igain_q  <= '0;
			dgain_q  <= '0;
			dlimit_q <= DLIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET: target_q <= cfg_data[SAMPLE_WIDTH-1:0];
				REG_HYST:   hyst_q   <= cfg_data[HYST_W-1:0];
				REG_LIMIT:  limit_q  <= cfg_data;
				REG_IGAIN:  igain_q  <= cfg_data;
				REG_DGAIN:  dgain_q  <= cfg_data;
				REG_DLIMIT: dlimit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			gain_q     <= GAIN_WIDTH'(32'h0001_0000);
			psample_q  <= '0;
			ptarget_q  <= '0;
			integ_q    <= '0;
			pend_q     <= 1'b0;
			sample_q   <= '0;
			ti_q       <= '0;
			td_q       <= '0;
			corr_q     <= '0;
			dose_q     <= '0;
			given_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we && (cfg_index == REG_TARGET)) begin
				ptarget_q <= target_q;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						sample_q <= s_tdata[SAMPLE_WIDTH-1:0];
						state_q  <= pend_q ? ST_TI_G : ST_DOSE;
					end
				end
				ST_TI_G: state_q <= ST_TI_W;
				ST_TI_W: begin
					if (mul_rsp.done) begin
						ti_q    <= mul_rsp.p[TERM_W+FRAC-1:FRAC];
						state_q <= ST_TD_G;
					end
				end
				ST_TD_G: state_q <= ST_TD_W;
				ST_TD_W: begin
					if (mul_rsp.done) begin
						td_q    <= mul_rsp.p[TERM_W+FRAC-1:FRAC];
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					// halved running integral, rounded toward minus infinity
					integ_q <= sum_i >>> 1;
					if (err_x > hyst_x) begin
						corr_q  <= signed'(CORR_W'(limit_q));
						state_q <= ST_CI;
					end else if (err_x < nhyst_x) begin
						if (limit_q == '0) begin
							corr_q  <= CORR_RECIP_MAX;
							state_q <= ST_CI;
						end else begin
							state_q <= ST_DV_G;
						end
					end else begin
						corr_q  <= CORR_ONE;
						state_q <= ST_CI;
					end
				end
				ST_DV_G: state_q <= ST_DV_W;
				ST_DV_W: begin
					if (div_rsp.done) begin
						corr_q  <= signed'(CORR_W'(div_rsp.quo));
						state_q <= ST_CI;
					end
				end
				ST_CI: begin
					if (integ_x > hyst_x) begin
						corr_q <= corr_q + ti_s;
					end else if (integ_x < nhyst_x) begin
						corr_q <= corr_q - ti_s;
					end
					state_q <= ST_CD;
				end
				ST_CD: begin
					if (diff_x > hyst_x) begin
						corr_q <= corr_q + td_s;
					end else if (diff_x < nhyst_x) begin
						corr_q <= corr_q - td_s;
					end
					state_q <= ST_GN_G;
				end
				ST_GN_G: begin
					// a correction that is not positive clears the gain
					if (corr_q <= 0) begin
						gain_q  <= '0;
						state_q <= ST_DOSE;
					end else begin
						state_q <= ST_GN_W;
					end
				end
				ST_GN_W: begin
					if (mul_rsp.done) begin
						gain_q  <= gain_new;
						state_q <= ST_DOSE;
					end
				end
				ST_DOSE: begin
					pend_q  <= dosed;
					given_q <= dosed;
					if (dosed) begin
						psample_q <= sample_q;
						ptarget_q <= target_q;
						state_q   <= ST_DS_G;
					end else begin
						dose_q  <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_DS_G: state_q <= ST_DS_W;
				ST_DS_W: begin
					if (mul_rsp.done) begin
						dose_q  <= dose_cap;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= dose_q;
						m_tuser_q  <= given_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == ST_TI_W || state_q == ST_TD_W ||
		                  state_q == ST_GN_W || state_q == ST_DS_W))
		else $error("multiplier result outside a wait state");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DV_W))
		else $error("divider result outside its wait state");

	a_no_dose_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tuser_q) |-> (m_tdata_q == '0))
		else $error("dose amount nonzero without a dose");

	a_pend_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (pend_q == $past(given_q)))
		else $error("adaptation flag does not follow dose decision");

endmodule

// ===== sim/tb_adaptive_gain_dose_controller.sv =====
`timescale 1ns / 1ps
// Drives pressure samples into the dose controller and checks every dose
// against a cycle-free predictor kept in step with the register writes.
module tb_adaptive_gain_dose_controller;
	import agdc_pkg::*;

	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 32;
	localparam int PRESS_FRAC = SAMPLE_W - 4;
	localparam longint unsigned GAIN_MAX = (64'd1 << GAIN_W) - 64'd1;

	// indexes with no register behind them; writes there must be dropped
	localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

	localparam int RAND_PHASES  = 6;
	localparam int PHASE_ITEMS  = 155;
	localparam int HOLD_AT      = 60;      // results seen before the long output stall
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 200;     // > worst request latency
	localparam int CYCLE_LIMIT  = 1000000;

	typedef struct packed {
		logic [31:0] amount;
		logic        given;
	} dose_rec_t;

	// DUT signals, all inputs known from time zero
	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [SAMPLE_W-1:0] s_tdata   = '0;  // [15:0] pressure_sample
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [31:0]         m_tdata;         // [31:0] dose_amount
	logic                m_tuser;         // [0] dose_given
	logic                cfg_we    = 1'b0;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [REG_W-1:0]    cfg_data  = '0;

	// predictor copy of registers and controller state
	logic [SAMPLE_W-1:0]      set_point, last_set_point, last_press;
	logic [HYST_W-1:0]        band;
	logic [REG_W-1:0]         lim_factor, int_weight, diff_weight, dose_cap;
	logic [GAIN_W-1:0]        gain_est;
	logic signed [SAMPLE_W+1:0] err_accum;
	logic                     adapt_due;

	logic [SAMPLE_W-1:0] press_q[$];     // samples waiting to be offered
	dose_rec_t           dose_due_q[$];  // predicted doses, oldest first

	int n_issued   = 0;
	int n_accepted = 0;
	int n_checked  = 0;
	int n_errors   = 0;
	int n_cycles   = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;

	adaptive_gain_dose_controller #(
		.SAMPLE_WIDTH(SAMPLE_W),
		.GAIN_WIDTH  (GAIN_W)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// (a * b) >> sh over the full 128-bit product, capped
	function automatic longint unsigned scaled_product(input longint unsigned a,
			input longint unsigned b, input int sh, input longint unsigned cap);
		logic [127:0] prod;
		prod = 128'(a) * 128'(b);
		prod = prod >> sh;
		if (prod > 128'(cap))
			return cap;
		return prod[63:0];
	endfunction

	// Advance the predictor by one accepted sample and queue its dose.
	task automatic predict_dose(input logic [SAMPLE_W-1:0] press);
		longint    hyst, err, last_err, diff, acc, corr, ti, td, mag;
		dose_rec_t rec;
		hyst = longint'(band);
		err  = longint'(set_point) - longint'(press);
		if (adapt_due) begin
			last_err = longint'(last_set_point) - longint'(last_press);
			diff = err - last_err;
			acc  = longint'(err_accum) + err;
			err_accum = (SAMPLE_W+2)'(acc >>> 1);  // floor of half
			ti = longint'((64'(lim_factor) * 64'(int_weight)) >> FRAC);
			td = longint'((64'(lim_factor) * 64'(diff_weight)) >> FRAC);
			// base factor from where the error lies against the band
			corr = longint'(CORR_ONE);
			if (err > hyst)
				corr = longint'(lim_factor);
			else if (err < -hyst)
				corr = (lim_factor == '0) ? longint'(CORR_RECIP_MAX)
				                          : longint'(CORR_RECIP_MAX) / longint'(lim_factor);
			if (longint'(err_accum) > hyst)
				corr += ti;
			else if (longint'(err_accum) < -hyst)
				corr -= ti;
			if (diff > hyst)
				corr += td;
			else if (diff < -hyst)
				corr -= td;
			// non-positive correction wipes the gain for good
			if (corr <= 0)
				gain_est = '0;
			else
				gain_est = GAIN_W'(scaled_product(gain_est, corr, FRAC, GAIN_MAX));
			adapt_due = 1'b0;
		end
		rec.amount = '0;
		rec.given  = 1'b0;
		if (longint'(press) < longint'(set_point) + hyst) begin
			mag = (err < 0) ? -err : err;
			rec.amount = 32'(scaled_product(mag, gain_est, PRESS_FRAC, dose_cap));
			rec.given  = 1'b1;
			last_press     = press;
			last_set_point = set_point;
			adapt_due      = 1'b1;
		end
		dose_due_q.push_back(rec);
	endtask

	// One register write; only called with the controller idle.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TARGET: begin
				last_set_point = set_point;
				set_point      = val[SAMPLE_W-1:0];
			end
			REG_HYST:   band        = val[HYST_W-1:0];
			REG_LIMIT:  lim_factor  = val;
			REG_IGAIN:  int_weight  = val;
			REG_DGAIN:  diff_weight = val;
			REG_DLIMIT: dose_cap    = val;
			default: ;
		endcase
	endtask

	task automatic issue_press(input logic [SAMPLE_W-1:0] press);
		press_q.push_back(press);
		n_issued++;
	endtask

	// wait until every queued request went in and its dose came back
	task automatic settle;
		do
			@(posedge clk);
		while (n_accepted != n_issued || dose_due_q.size() != 0);
	endtask

	// sample scattered around the current set point, clamped to the field
	function automatic logic [SAMPLE_W-1:0] near_press(input int spread);
		int v;
		v = int'(set_point) + int'($urandom_range(2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[SAMPLE_W-1:0];
	endfunction

	// Request driver: keeps tdata stable while a request waits for tready.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_dose(s_tdata);
				n_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (press_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tdata  <= press_q.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result side ready: random stalls plus one long hold-off so the output
	// register fills and the controller has to back-pressure its input.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (!hold_done && n_checked >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Result monitor: compare each dose with the oldest prediction.
	always @(posedge clk) begin
		dose_rec_t due;
		if (arst_n && m_tvalid && m_tready) begin
			if (dose_due_q.size() == 0) begin
				$display("%0t: unexpected result, dose_amount %h dose_given %b",
					$time, m_tdata, m_tuser);
				n_errors++;
			end else begin
				due = dose_due_q.pop_front();
				if (m_tdata !== due.amount) begin
					$display("%0t: dose_amount expected %h actual %h",
						$time, due.amount, m_tdata);
					n_errors++;
				end
				if (m_tuser !== due.given) begin
					$display("%0t: dose_given expected %b actual %b",
						$time, due.given, m_tuser);
					n_errors++;
				end
			end
			n_checked++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d of %0d requests checked", $time, n_checked, n_issued);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		// predictor matches the register and state reset values
		set_point      = '0;
		last_set_point = '0;
		last_press     = '0;
		band           = '0;
		lim_factor     = LIMIT_RST;
		int_weight     = '0;
		diff_weight    = '0;
		dose_cap       = DLIMIT_RST;
		gain_est       = 32'h0001_0000;
		err_accum      = '0;
		adapt_due      = 1'b0;

		send_idle_pct = 25;
		recv_idle_pct = 85;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed part ---
		// zero set point and band: sample equal to target gets no dose
		issue_press(16'h0000);
		issue_press(16'hFFFF);
		settle();
		write_reg(REG_TARGET, 32'h0000_FFFF);
		issue_press(16'h0000);  // largest error, dosed
		issue_press(16'hFFFF);  // equal to target again, adapts inside band
		settle();
		// widest band, integral and difference terms active
		write_reg(REG_HYST, 32'h0000_0FFF);
		write_reg(REG_IGAIN, 32'h0000_1000);
		write_reg(REG_DGAIN, 32'h0000_0800);
		issue_press(16'h8000);
		issue_press(16'h0800);  // above band, gain grows
		issue_press(16'hF800);  // inside band
		settle();
		write_reg(REG_TARGET, 32'h0000_4000);
		issue_press(16'hC000);  // below band, reciprocal path, no dose
		settle();
		// largest factor: gain saturates, then recovers via reciprocal of one
		write_reg(REG_DLIMIT, 32'h0000_1000);
		write_reg(REG_LIMIT, 32'hFFFF_FFFF);
		write_reg(REG_IGAIN, 32'h0000_0000);
		write_reg(REG_DGAIN, 32'h0000_0000);
		write_reg(REG_HYST, 32'h0000_0010);
		issue_press(16'h2000);  // dose clipped at the small limit
		issue_press(16'h0000);  // gain saturates
		issue_press(16'hFFFF);  // factor 1/max brings gain back near 1.0
		settle();
		write_reg(REG_DLIMIT, 32'h0000_0000);
		write_reg(REG_LIMIT, LIMIT_RST);
		issue_press(16'h3FF0);  // dose forced to zero by a zero limit
		settle();
		// unused indexes must not disturb anything
		write_reg(REG_DLIMIT, DLIMIT_RST);
		write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_B, 32'h0000_0000);
		issue_press(16'h4005);
		issue_press(16'h4010);  // exactly target plus band, no dose
		issue_press(16'h400F);  // one below, dosed
		settle();

		// --- random part: factors kept near 1.0 so the gain stays alive ---
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph / 2)
				0: begin
					send_idle_pct = 25;
					recv_idle_pct = 85;
				end
				1: begin
					send_idle_pct = 85;
					recv_idle_pct = 25;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_reg(REG_TARGET, $urandom_range(16'hFFFF));
			write_reg(REG_HYST, ($urandom_range(3) == 0) ? $urandom_range(12'hFFF)
			                                             : $urandom_range(255));
			write_reg(REG_LIMIT, $urandom_range(69632, 61440));
			write_reg(REG_IGAIN, $urandom_range(4095));
			write_reg(REG_DGAIN, $urandom_range(4095));
			write_reg(REG_DLIMIT, ($urandom_range(2) == 0) ? $urandom_range(32'h0004_0000)
			                                               : DLIMIT_RST);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(9) < 7)
					issue_press(near_press(2 * int'(band) + 256));
				else
					issue_press($urandom_range(16'hFFFF));
			end
			settle();
		end

		// --- end of run: settings that can destroy the gain ---
		// huge weights drive the correction far positive or negative
		write_reg(REG_TARGET, 32'h0000_8000);
		write_reg(REG_HYST, 32'd32);
		write_reg(REG_IGAIN, 32'hFFFF_FFFF);
		write_reg(REG_DGAIN, 32'hFFFF_FFFF);
		repeat (6) issue_press(near_press(512));
		settle();
		// zero factor: reciprocal taken as 2^32, base above band is zero
		write_reg(REG_LIMIT, 32'd0);
		write_reg(REG_IGAIN, 32'd0);
		write_reg(REG_DGAIN, 32'd0);
		issue_press(16'h7000);
		issue_press(16'hF000);  // below band
		issue_press(16'h7800);
		issue_press(16'h1000);  // above band, gain cleared
		issue_press(16'h7000);
		settle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0 && dose_due_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/agdc_pkg.sv
sv/agdc_mul.sv
sv/agdc_div.sv
sv/adaptive_gain_dose_controller.sv
sim/tb_adaptive_gain_dose_controller.sv
